// ===== hdl/rbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants of the rANS byte encoder.
// ----------------------------------------------------------------------------
package rbe_pkg;

   localparam int PROB_BITS   = 15;
   localparam int STATE_W     = 32;
   localparam int OP_W        = 2;
   localparam int SYMBOL_W    = 8;
   localparam int FREQ_W      = 16;
   localparam int CUMUL_W     = 15;
   localparam int BYTE_W      = 8;
   localparam int TABLE_W     = FREQ_W + CUMUL_W;
   localparam int TABLE_DEPTH = 1 << SYMBOL_W;

   // state is renormalised below freq << EMIT_SHIFT, so the quotient has EMIT_SHIFT bits
   localparam int EMIT_SHIFT  = STATE_W - 1 - PROB_BITS;
   localparam int Q_BITS      = EMIT_SHIFT;
   localparam int STEP_W      = $clog2(Q_BITS);

   localparam int STATE_BYTES = STATE_W / BYTE_W;
   localparam int CNT_W       = $clog2(STATE_BYTES + 1);

   localparam logic [STATE_W-1:0] STATE_RESET = STATE_W'(1) << 23;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FLUSH
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/rans_byte_encoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rans_byte_encoder_top
// Byte-wise rANS encoder, 15-bit probability scale, bit-serial division.
// ----------------------------------------------------------------------------
// One request at a time. A table write (op 0) gives no output. An encode
// (op 1) is accepted, reads the table, renormalises (0..2 bytes emitted,
// one per cycle while the output register is free), runs the restoring
// divider at one quotient bit per cycle, then updates the state. A zero
// frequency ends after the table read with a single error output, state
// untouched. A flush (op 2) emits the four state bytes, one per cycle while
// the output register is free, and restarts the state at 2^23. Op 3 is
// accepted and ignored. Under back-pressure a further byte waits on a full
// output register.
// The symbol table sits in a 256 x 31 RAM; entries never written read as
// anything. Results leave through one output register, so a byte waits there
// while the block goes on.
// ----------------------------------------------------------------------------
module rans_byte_encoder_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [rbe_pkg::OP_W-1:0]      req_op,
   input  wire logic [rbe_pkg::SYMBOL_W-1:0]  req_symbol,
   input  wire logic [rbe_pkg::FREQ_W-1:0]    req_freq,
   input  wire logic [rbe_pkg::CUMUL_W-1:0]   req_cumul,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [rbe_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                               rsp_from_state,
   output logic                               rsp_last,
   output logic                               rsp_error
);

   import rbe_pkg::*;

   // control
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;        // bytes emitted for this request
   logic [STEP_W-1:0]    step_ff, step_in;      // divider step

   // coder state and symbol entry
   logic [STATE_W-1:0]   s_ff, s_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [CUMUL_W-1:0]   cumul_ff, cumul_in;

   // divider: partial remainder, dividend bits still to shift in, quotient
   logic [FREQ_W-1:0]    rem_ff, rem_in;
   logic [Q_BITS-1:0]    dvd_ff, dvd_in;
   logic [Q_BITS-1:0]    quo_ff, quo_in;
   logic [FREQ_W:0]      trial;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_out_byte_ff, rsp_out_byte_in;
   logic                 rsp_from_state_ff, rsp_from_state_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_error_ff, rsp_error_in;
   logic                 out_load;
   logic                 out_free;

   // table RAM
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [TABLE_W-1:0]   ram_rd_data;

   logic                 freq_zero;
   logic                 emit_now;
   logic                 emit_next;

   rbe_ram #(
      .WIDTH (TABLE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_symbol),
      .wr_data ({req_freq, req_cumul}),
      .rd_en   (ram_rd_en),
      .rd_addr (req_symbol),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign freq_zero = (freq_ff == '0);

   // renormalise while state >= freq << EMIT_SHIFT, at most four bytes;
   // emit_next tells whether the byte now leaving is the last one
   assign emit_now  = ((s_ff >> EMIT_SHIFT) >= STATE_W'(freq_ff))
                   && (cnt_ff != CNT_W'(STATE_BYTES));
   assign emit_next = ((s_ff >> (EMIT_SHIFT + BYTE_W)) >= STATE_W'(freq_ff))
                   && (cnt_ff != CNT_W'(STATE_BYTES - 1));

   // restoring divider step: shift in next dividend bit, try subtract
   assign trial = {rem_ff, dvd_ff[Q_BITS-1]} - {1'b0, freq_ff};

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_ENCODE: state_in = ST_LOOKUP;
                  OP_FLUSH:  state_in = ST_FLUSH;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: state_in = ST_EMIT;
         ST_EMIT: begin
            if (freq_zero) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (!emit_now) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_W'(Q_BITS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_FLUSH: begin
            if (out_free && cnt_ff == CNT_W'(STATE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --- outputs and datapath ---
   always_comb begin
      req_ready         = 1'b0;
      ram_wr_en         = 1'b0;
      ram_rd_en         = 1'b0;
      out_load          = 1'b0;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_from_state_in = rsp_from_state_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_error_in      = rsp_error_ff;
      s_in              = s_ff;
      cnt_in            = cnt_ff;
      step_in           = step_ff;
      freq_in           = freq_ff;
      cumul_in          = cumul_ff;
      rem_in            = rem_ff;
      dvd_in            = dvd_ff;
      quo_in            = quo_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               case (req_op)
                  OP_WRITE:  ram_wr_en = 1'b1;
                  OP_ENCODE: ram_rd_en = 1'b1;
                  default:   ;
               endcase
            end
         end
         ST_LOOKUP: begin
            freq_in  = ram_rd_data[TABLE_W-1:CUMUL_W];
            cumul_in = ram_rd_data[CUMUL_W-1:0];
         end
         ST_EMIT: begin
            if (freq_zero) begin
               if (out_free) begin
                  out_load          = 1'b1;
                  rsp_out_byte_in   = '0;
                  rsp_from_state_in = 1'b0;
                  rsp_last_in       = 1'b1;
                  rsp_error_in      = 1'b1;
               end
            end else if (emit_now) begin
               if (out_free) begin
                  out_load          = 1'b1;
                  rsp_out_byte_in   = s_ff[BYTE_W-1:0];
                  rsp_from_state_in = 1'b0;
                  rsp_last_in       = !emit_next;
                  rsp_error_in      = 1'b0;
                  s_in              = s_ff >> BYTE_W;
                  cnt_in            = cnt_ff + CNT_W'(1);
               end
            end else begin
               // state < freq << EMIT_SHIFT here, so the top part is below freq
               rem_in  = FREQ_W'(s_ff >> EMIT_SHIFT);
               dvd_in  = s_ff[Q_BITS-1:0];
               quo_in  = '0;
               step_in = '0;
            end
         end
         ST_DIVIDE: begin
            if (!trial[FREQ_W]) begin
               rem_in = trial[FREQ_W-1:0];
            end else begin
               rem_in = {rem_ff[FREQ_W-2:0], dvd_ff[Q_BITS-1]};
            end
            quo_in  = {quo_ff[Q_BITS-2:0], !trial[FREQ_W]};
            dvd_in  = {dvd_ff[Q_BITS-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
         end
         ST_UPDATE: begin
            s_in = (STATE_W'(quo_ff) << PROB_BITS) + STATE_W'(cumul_ff)
                 + STATE_W'(rem_ff);
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load          = 1'b1;
               rsp_out_byte_in   = s_ff[BYTE_W-1:0];
               rsp_from_state_in = 1'b1;
               rsp_last_in       = (cnt_ff == CNT_W'(STATE_BYTES - 1));
               rsp_error_in      = 1'b0;
               cnt_in            = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(STATE_BYTES - 1)) begin
                  s_in = STATE_RESET;
               end else begin
                  s_in = s_ff >> BYTE_W;
               end
            end
         end
         default: ;
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   // --- registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s_ff         <= STATE_RESET;
         cnt_ff       <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s_ff         <= s_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff           <= freq_in;
      cumul_ff          <= cumul_in;
      rem_ff            <= rem_in;
      dvd_ff            <= dvd_in;
      quo_ff            <= quo_in;
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_from_state_ff <= rsp_from_state_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_error_ff      <= rsp_error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_from_state = rsp_from_state_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error      = rsp_error_ff;

endmodule
`default_nettype wire

// ===== hdl/rbe_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sim/rans_byte_encoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// rans_byte_encoder_top_tb
// Self-checking bench for the rANS byte encoder. A short directed table covers
// table writes, zero-frequency errors, flushes, the unused op and extreme
// field values. Random messages follow: table rewrites, runs of encodes over
// written symbols, then a flush. Every accepted request is run through a
// behavioural coder kept here, and the emitted bytes are checked in order.
// ----------------------------------------------------------------------------
module rans_byte_encoder_top_tb;

   import rbe_pkg::*;

   // op 3 is not in the package enum; the block must swallow it silently
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // bytes leave the state while state >= RENORM_BOUND * freq
   localparam longint unsigned RENORM_BOUND =
      longint'(STATE_RESET >> PROB_BITS) << BYTE_W;

   localparam int MAX_WAIT     = 10;      // longest idle gap on either side
   localparam int RANDOM_ITEMS = 240;
   localparam int DRAIN_CYCLES = 60;      // covers the slowest encode plus a stall
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [SYMBOL_W-1:0] symbol;
      logic [FREQ_W-1:0]   freq;
      logic [CUMUL_W-1:0]  cumul;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              from_state;
      logic              last;
      logic              error;
   } emit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [SYMBOL_W-1:0] req_symbol;
   logic [FREQ_W-1:0]   req_freq;
   logic [CUMUL_W-1:0]  req_cumul;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_from_state;
   logic                rsp_last;
   logic                rsp_error;

   // behavioural coder: state and symbol table
   logic [STATE_W-1:0] coder_st = STATE_RESET;
   logic [FREQ_W-1:0]  freq_tab  [TABLE_DEPTH];
   logic [CUMUL_W-1:0] cumul_tab [TABLE_DEPTH];
   bit                 written   [TABLE_DEPTH];

   emit_type step_bytes    [$];   // bytes caused by the request just accepted
   emit_type awaited_bytes [$];   // bytes still to come out of the block

   // directed table: requests, typed result count (-1: use the coder), typed bytes
   req_type  dir_req    [$];
   int       dir_ntyped [$];
   emit_type dir_typed  [$];

   int  error_count  = 0;
   int  cycle_count  = 0;
   bit  quiet_tx     = 1'b0;
   bit  quiet_rx     = 1'b0;

   rans_byte_encoder_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_symbol     (req_symbol),
      .req_freq       (req_freq),
      .req_cumul      (req_cumul),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_from_state (rsp_from_state),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop: covers a hung handshake and bytes that never arrive
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rans_byte_encoder_top_tb: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      error_count++;
   endtask

   // One request through the coder; the bytes it causes go to step_bytes.
   task automatic rans_encode_step(input req_type r);
      longint unsigned st, lim, f, q, rem;
      emit_type        e;
      int              n;
      int              i;
      n = 0;
      f = 64'(freq_tab[r.symbol]);
      case (r.op)
         OP_WRITE: begin
            freq_tab[r.symbol]  = r.freq;
            cumul_tab[r.symbol] = r.cumul;
         end
         OP_ENCODE: begin
            if (f == 0) begin
               // zero frequency: lone error byte, state left alone
               e = {8'h00, 1'b0, 1'b1, 1'b1};
               step_bytes.push_back(e);
            end else begin
               st  = 64'(coder_st);
               lim = RENORM_BOUND * f;   // full width, no wrap for big freq
               while (st >= lim && n < STATE_BYTES) begin
                  e.out_byte   = st[BYTE_W-1:0];
                  e.from_state = 1'b0;
                  e.error      = 1'b0;
                  st           = st >> BYTE_W;
                  n++;
                  e.last       = (st < lim) || (n == STATE_BYTES);
                  step_bytes.push_back(e);
               end
               q   = st / f;
               rem = st % f;
               // cumul + freq past the scale is not checked; just wrap to 32 bits
               coder_st = STATE_W'((q << PROB_BITS) + 64'(cumul_tab[r.symbol]) + rem);
            end
         end
         OP_FLUSH: begin
            for (i = 0; i < STATE_BYTES; i++) begin
               e = {coder_st[BYTE_W*i +: BYTE_W], 1'b1, i == STATE_BYTES - 1, 1'b0};
               step_bytes.push_back(e);
            end
            coder_st = STATE_RESET;
         end
         default: ;   // unused op: nothing happens
      endcase
   endtask

   task automatic dir_row(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                          input logic [FREQ_W-1:0] f, input logic [CUMUL_W-1:0] c,
                          input int n_typed);
      req_type r;
      r = {op, sym, f, c};
      dir_req.push_back(r);
      dir_ntyped.push_back(n_typed);
   endtask

   task automatic dir_byte(input logic [BYTE_W-1:0] b, input logic fs,
                           input logic last, input logic err);
      emit_type e;
      e = {b, fs, last, err};
      dir_typed.push_back(e);
   endtask

   // Drive one request from the falling edge, hold it until taken, then
   // record what it should produce. n_typed >= 0 takes hand-written bytes.
   task automatic send_request(input req_type r, input int n_typed);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= r.op;
      req_symbol <= r.symbol;
      req_freq   <= r.freq;
      req_cumul  <= r.cumul;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.op == OP_WRITE)
         written[r.symbol] = 1'b1;
      rans_encode_step(r);
      if (n_typed < 0) begin
         while (step_bytes.size() > 0)
            awaited_bytes.push_back(step_bytes.pop_front());
      end else begin
         step_bytes.delete();
         repeat (n_typed) awaited_bytes.push_back(dir_typed.pop_front());
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side: directed table, random messages, then drain and verdict.
   // ---------------------------------------------------------------------
   initial begin
      req_type r;
      int      i;
      int      k;
      int      sel;
      int      msg_left;
      int      rnd_count;

      req_valid  = 1'b0;
      req_op     = OP_WRITE;
      req_symbol = '0;
      req_freq   = '0;
      req_cumul  = '0;
      msg_left   = 0;
      rnd_count  = 0;

      // flush straight after reset: the reset state 2^23, low byte first
      dir_row(OP_FLUSH, 8'h00, 16'h0000, 15'h0000, 4);
      dir_byte(8'h00, 1'b1, 1'b0, 1'b0);
      dir_byte(8'h00, 1'b1, 1'b0, 1'b0);
      dir_byte(8'h80, 1'b1, 1'b0, 1'b0);
      dir_byte(8'h00, 1'b1, 1'b1, 1'b0);
      dir_row(OP_UNUSED, 8'hFF, 16'hFFFF, 15'h7FFF, 0);   // ignored
      dir_row(OP_WRITE,  8'h00, 16'h0000, 15'h0000, 0);   // zero-frequency entry
      dir_row(OP_ENCODE, 8'h00, 16'h0000, 15'h0000, 1);
      dir_byte(8'h00, 1'b0, 1'b1, 1'b1);
      dir_row(OP_WRITE,  8'hFF, 16'h8000, 15'h0000, 0);   // full scale
      dir_row(OP_WRITE,  8'h01, 16'h0001, 15'h7FFF, 0);   // smallest freq, top cumul
      dir_row(OP_WRITE,  8'hAA, 16'h5555, 15'h2AAA, 0);
      dir_row(OP_WRITE,  8'h55, 16'h2AAA, 15'h5555, 0);
      dir_row(OP_ENCODE, 8'hFF, 16'h0000, 15'h0000, -1);
      dir_row(OP_ENCODE, 8'h01, 16'h0000, 15'h0000, -1);
      dir_row(OP_ENCODE, 8'h01, 16'h0000, 15'h0000, -1);
      dir_row(OP_ENCODE, 8'hAA, 16'h0000, 15'h0000, -1);
      dir_row(OP_ENCODE, 8'h55, 16'h0000, 15'h0000, -1);
      dir_row(OP_FLUSH,  8'h00, 16'h0000, 15'h0000, -1);
      dir_row(OP_ENCODE, 8'hAA, 16'h0000, 15'h0000, -1);  // no byte leaves
      dir_row(OP_ENCODE, 8'h01, 16'h0000, 15'h0000, -1);
      dir_row(OP_ENCODE, 8'h01, 16'h0000, 15'h0000, -1);
      dir_row(OP_FLUSH,  8'h00, 16'h0000, 15'h0000, -1);
      dir_row(OP_WRITE,  8'h80, 16'd100,  15'd32700, 0);  // cumul + freq past scale
      dir_row(OP_ENCODE, 8'h80, 16'h0000, 15'h0000, -1);
      dir_row(OP_ENCODE, 8'h00, 16'h0000, 15'h0000, 1);
      dir_byte(8'h00, 1'b0, 1'b1, 1'b1);
      dir_row(OP_ENCODE, 8'hFF, 16'h0000, 15'h0000, -1);
      dir_row(OP_UNUSED, 8'h00, 16'h0000, 15'h0000, 0);
      dir_row(OP_FLUSH,  8'h00, 16'h0000, 15'h0000, -1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < dir_req.size(); i++)
         send_request(dir_req[i], dir_ntyped[i]);

      // Random messages: mostly encodes of written symbols closed by a flush,
      // with table rewrites (some to zero frequency) and the odd unused op.
      while (rnd_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0)
            quiet_tx = !quiet_tx;
         k = $urandom_range(0, 99);
         r.symbol = SYMBOL_W'($urandom_range(0, TABLE_DEPTH - 1));
         r.freq   = '0;
         r.cumul  = CUMUL_W'($urandom_range(0, (1 << CUMUL_W) - 1));
         if (msg_left == 0) begin
            r.op     = OP_FLUSH;
            msg_left = $urandom_range(1, 20);
         end else if (k < 4) begin
            r.op   = OP_UNUSED;
            r.freq = FREQ_W'($urandom_range(0, (1 << FREQ_W) - 1));
         end else if (k < 18) begin
            r.op = OP_WRITE;
            sel  = $urandom_range(0, 9);
            case (sel)
               0:       r.freq = '0;
               1, 2, 3: r.freq = FREQ_W'($urandom_range(1, 16));
               4, 5, 6: r.freq = FREQ_W'($urandom_range(1, 4096));
               7, 8:    r.freq = FREQ_W'($urandom_range(1, 1 << PROB_BITS));
               default: r.freq = FREQ_W'(1 << PROB_BITS);
            endcase
         end else begin
            // never encode an entry that was not written
            r.op = OP_ENCODE;
            while (!written[r.symbol])
               r.symbol = SYMBOL_W'($urandom_range(0, TABLE_DEPTH - 1));
            msg_left--;
         end
         send_request(r, -1);
         if (r.op != OP_UNUSED)
            rnd_count++;
      end

      @(negedge clock);
      req_valid <= 1'b0;

      while (awaited_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);   // catch stray late bytes

      if (error_count == 0)
         $display("rans_byte_encoder_top_tb: done, clean");
      else
         $display("rans_byte_encoder_top_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random stalls per byte, field-by-field check in order.
   // ---------------------------------------------------------------------
   initial begin
      int       stall;
      emit_type got;
      emit_type want;

      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 24) == 0)
            quiet_rx = !quiet_rx;
         stall = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = {rsp_out_byte, rsp_from_state, rsp_last, rsp_error};
         if (awaited_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h fs %b last %b err %b",
                                      got.out_byte, got.from_state, got.last, got.error));
         end else begin
            want = awaited_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         got.out_byte, want.out_byte));
            if (got.from_state !== want.from_state)
               report_mismatch($sformatf("from_state %b, expected %b",
                                         got.from_state, want.from_state));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            if (got.error !== want.error)
               report_mismatch($sformatf("error %b, expected %b", got.error, want.error));
         end
      end
   end

endmodule

// ===== rans_byte_encoder_top.f =====
hdl/rbe_pkg.sv
hdl/rbe_ram.sv
hdl/rans_byte_encoder_top.sv
sim/rans_byte_encoder_top_tb.sv
